// ===== rtl/core/fdep_pkg.sv =====
// ----------------------------------------------------------------------------
// fdep_pkg
// Types and constants shared by the FAT directory entry parser modules.
// ----------------------------------------------------------------------------
package fdep_pkg;

  // Input modes
  localparam logic [1:0] MODE_FEED    = 2'd0;
  localparam logic [1:0] MODE_READ    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  // Directory entry codes
  localparam logic [7:0] ERASED_MARK = 8'hE5;
  localparam logic [7:0] ATTR_LFN    = 8'h0F;
  localparam logic [7:0] ATTR_VOLUME = 8'h08;
  localparam logic [3:0] LFN_LAST    = 4'h4;
  localparam logic [7:0] CHR_SPACE   = 8'h20;
  localparam logic [7:0] CHR_DOT     = 8'h2E;
  localparam logic [7:0] LFN_CHARS   = 8'd13;

  // Longest write list: 13 characters plus terminator
  localparam int CHAR_SLOTS = 14;
  // Result queue depth in the back end
  localparam int OUT_DEPTH  = 4;

  // Byte offsets of the low character bytes in a long-name entry
  localparam logic [4:0] LFN_OFS [13] = '{5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd14,
                                          5'd16, 5'd18, 5'd20, 5'd22, 5'd24,
                                          5'd28, 5'd30};

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_READY = 2'd1,
    EV_END   = 2'd2,
    EV_READ  = 2'd3
  } event_t;

  // Command handed from front to back
  typedef struct packed {
    event_t                          ev;
    logic [7:0]                      addr;   // read index or write base
    logic [3:0]                      cnt;    // store writes to perform
    logic [CHAR_SLOTS-1:0][7:0]      chars;
    logic                            writable;
    logic                            hidden;
    logic                            directory;
    logic [31:0]                     cluster;
    logic [31:0]                     size;
  } cmd_t;

  // Result item
  typedef struct packed {
    event_t      ev;
    logic [7:0]  name_char;
    logic        writable;
    logic        hidden;
    logic        directory;
    logic [31:0] cluster;
    logic [31:0] size;
  } res_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c, input logic low);
    logic [7:0] r;
    r = c;
    if (low && c >= 8'h41 && c <= 8'h5A) r = c + 8'd32;
    return r;
  endfunction

endpackage

// ===== rtl/core/fdep_front.sv =====
// ----------------------------------------------------------------------------
// fdep_front
// Collects entry bytes, decodes full entries and emits one command per item.
// ----------------------------------------------------------------------------
module fdep_front import fdep_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [1:0]  mode,
  input  logic [7:0]  entry_byte,
  input  logic [7:0]  read_index,
  output cmd_t        cmd
);

  logic [4:0]       pos_r, pos_nxt;
  logic [3:0]       pend_r, pend_nxt;
  logic             ended_r, ended_nxt;
  logic [30:0][7:0] buf_r;
  logic [31:0][7:0] ent;

  logic [7:0] first, attr;
  logic [3:0] seq;
  logic [3:0] lfn_n;
  logic       lfn_stop;
  logic [3:0] base_len;
  logic       base_stop;
  logic [1:0] ext_len;
  logic       ext_stop;
  logic       has_ext;
  logic [3:0] j4;

  // Entry view with the incoming byte as the last one
  always_comb begin
    for (int i = 0; i < 31; i++) ent[i] = buf_r[i];
    ent[31] = entry_byte;
  end

  always_comb begin
    pos_nxt   = pos_r;
    pend_nxt  = pend_r;
    ended_nxt = ended_r;
    cmd       = '0;
    cmd.ev    = EV_NONE;
    first     = ent[0];
    attr      = ent[11];
    seq       = first[3:0];
    // first zero pair in the long-name slots
    lfn_n     = 4'd13;
    lfn_stop  = 1'b0;
    for (int k = 0; k < 13; k++) begin
      if (!lfn_stop && ent[LFN_OFS[k]] == 8'h00 && ent[LFN_OFS[k] + 5'd1] == 8'h00) begin
        lfn_n    = 4'(k);
        lfn_stop = 1'b1;
      end
    end
    // short name lengths
    base_len  = 4'd8;
    base_stop = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (!base_stop && ent[k] == CHR_SPACE) begin
        base_len  = 4'(k);
        base_stop = 1'b1;
      end
    end
    ext_len  = 2'd3;
    ext_stop = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (!ext_stop && ent[8+k] == CHR_SPACE) begin
        ext_len  = 2'(k);
        ext_stop = 1'b1;
      end
    end
    has_ext = (ent[8] != CHR_SPACE);
    j4      = '0;

    if (accept) begin
      case (mode)
        MODE_READ: begin
          cmd.ev   = EV_READ;
          cmd.addr = read_index;
        end
        MODE_RESTART: begin
          pos_nxt   = '0;
          pend_nxt  = '0;
          ended_nxt = 1'b0;
        end
        MODE_FEED: begin
          if (!ended_r) begin
            if (pos_r == 5'd0 && entry_byte == 8'h00) begin
              ended_nxt = 1'b1;
              cmd.ev    = EV_END;
            end else if (pos_r != 5'd31) begin
              pos_nxt = pos_r + 5'd1;
            end else begin
              // full entry decode
              pos_nxt = '0;
              if (first == ERASED_MARK) begin
                pend_nxt = '0;
              end else if (attr == ATTR_LFN) begin
                if (seq != 4'd0) begin
                  pend_nxt = seq;
                  cmd.addr = ({4'd0, seq} - 8'd1) * LFN_CHARS;
                  cmd.cnt  = lfn_n + 4'(first[7:4] == LFN_LAST);
                  for (int k = 0; k < 13; k++) begin
                    if (4'(k) < lfn_n) cmd.chars[k] = ent[LFN_OFS[k]];
                  end
                end
              end else if (attr != ATTR_VOLUME) begin
                cmd.ev        = EV_READY;
                cmd.writable  = ~attr[0];
                cmd.hidden    = attr[1];
                cmd.directory = attr[4];
                cmd.cluster   = {ent[21], ent[20], ent[27], ent[26]};
                cmd.size      = {ent[31], ent[30], ent[29], ent[28]};
                pend_nxt      = '0;
                if (pend_r != 4'd1) begin
                  cmd.addr = '0;
                  cmd.cnt  = has_ext ? base_len + 4'd2 + {2'd0, ext_len}
                                     : base_len + 4'd1;
                  for (int j = 0; j < CHAR_SLOTS; j++) begin
                    j4 = 4'(j);
                    if (j4 < base_len) begin
                      cmd.chars[j] = to_lower(ent[j % 8], ent[12][3]);
                    end else if (has_ext && j4 == base_len) begin
                      cmd.chars[j] = CHR_DOT;
                    end else begin
                      for (int e = 0; e < 3; e++) begin
                        if (has_ext && j4 == base_len + 4'd1 + 4'(e)
                            && 2'(e) < ext_len) begin
                          cmd.chars[j] = to_lower(ent[8+e], ent[12][4]);
                        end
                      end
                    end
                  end
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      pend_r  <= '0;
      ended_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      pend_r  <= pend_nxt;
      ended_r <= ended_nxt;
    end
  end

  // Entry byte buffer
  always_ff @(posedge clk) begin
    if (accept && mode == MODE_FEED && !ended_r && pos_r != 5'd31
        && !(pos_r == 5'd0 && entry_byte == 8'h00)) begin
      buf_r[pos_r] <= entry_byte;
    end
  end

endmodule

// ===== rtl/core/fdep_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// fdep_cmd_fifo
// Command queue between the front and back ends.
// ----------------------------------------------------------------------------
module fdep_cmd_fifo import fdep_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output logic rd_valid,
  output cmd_t rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign full     = (cnt_r == CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      if (rd_en) rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      if (wr_en && !rd_en)      cnt_r <= cnt_r + CW'(1);
      else if (rd_en && !wr_en) cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

endmodule

// ===== rtl/core/fdep_back.sv =====
// ----------------------------------------------------------------------------
// fdep_back
// Executes commands: name store writes, reads, and the result queue.
// ----------------------------------------------------------------------------
module fdep_back import fdep_pkg::*; #(
  parameter int NAME_DEPTH = 256
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  output res_t res,
  output logic res_empty,
  input  logic res_pop
);

  localparam int AW = $clog2(NAME_DEPTH);
  localparam int QW = $clog2(OUT_DEPTH);
  localparam int OW = $clog2(OUT_DEPTH + 1);

  logic [7:0]    store [NAME_DEPTH];
  logic [3:0]    wr_idx_r;
  logic          wr_act;
  logic [8:0]    wr_addr;
  logic          p1_v_r;
  cmd_t          p1_r;
  logic          p1_oob_r;
  logic [7:0]    rdata_r;
  res_t          q_r [OUT_DEPTH];
  logic [QW-1:0] qw_r, qr_r;
  logic [OW-1:0] qcnt_r;
  res_t          push_res;
  logic          q_pop;

  // Store write sequencing
  assign wr_act  = cmd_valid && (wr_idx_r < cmd.cnt);
  assign wr_addr = {1'b0, cmd.addr} + {5'd0, wr_idx_r};
  assign cmd_pop = cmd_valid && !wr_act
                   && ({1'b0, qcnt_r} + {{OW{1'b0}}, p1_v_r}) < (OW+1)'(OUT_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
    end else if (cmd_pop) begin
      wr_idx_r <= '0;
    end else if (wr_act) begin
      wr_idx_r <= wr_idx_r + 4'd1;
    end
  end

  // Name store
  always_ff @(posedge clk) begin
    if (wr_act && wr_addr < 9'(NAME_DEPTH)) begin
      store[wr_addr[AW-1:0]] <= cmd.chars[wr_idx_r];
    end
    if (cmd_pop) rdata_r <= store[cmd.addr[AW-1:0]];
  end

  // Read stage
  always_ff @(posedge clk) begin
    if (!rst_n) p1_v_r <= 1'b0;
    else        p1_v_r <= cmd_pop;
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      p1_r     <= cmd;
      p1_oob_r <= ({1'b0, cmd.addr} >= 9'(NAME_DEPTH));
    end
  end

  always_comb begin
    push_res.ev        = p1_r.ev;
    push_res.name_char = (p1_r.ev == EV_READ && !p1_oob_r) ? rdata_r : 8'h00;
    push_res.writable  = p1_r.writable;
    push_res.hidden    = p1_r.hidden;
    push_res.directory = p1_r.directory;
    push_res.cluster   = p1_r.cluster;
    push_res.size      = p1_r.size;
  end

  // Result queue
  assign res_empty = (qcnt_r == '0);
  assign res       = q_r[qr_r];
  assign q_pop     = res_pop && !res_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qw_r   <= '0;
      qr_r   <= '0;
      qcnt_r <= '0;
    end else begin
      if (p1_v_r) qw_r <= (qw_r == QW'(OUT_DEPTH - 1)) ? '0 : qw_r + QW'(1);
      if (q_pop)  qr_r <= (qr_r == QW'(OUT_DEPTH - 1)) ? '0 : qr_r + QW'(1);
      if (p1_v_r && !q_pop)      qcnt_r <= qcnt_r + OW'(1);
      else if (q_pop && !p1_v_r) qcnt_r <= qcnt_r - OW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (p1_v_r) q_r[qw_r] <= push_res;
  end

  // Checks
  a_q_room: assert property (@(posedge clk) disable iff (!rst_n)
    p1_v_r |-> qcnt_r < OW'(OUT_DEPTH))
    else $error("result queue overrun");

  a_idx_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |=> wr_idx_r == 4'd0)
    else $error("write index not cleared after pop");

  a_wr_contig: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_act && wr_idx_r != 4'd0) |-> $past(wr_act))
    else $error("store write burst broken");

endmodule

// ===== rtl/core/fat_directory_entry_parser.sv =====
// ----------------------------------------------------------------------------
// fat_directory_entry_parser
// Rebuilds FAT file names from a byte stream of directory entries.
// ----------------------------------------------------------------------------
// Input queue: drive in_mode/in_entry_byte/in_read_index with push while full
// is low. Mode feed sends one directory byte, mode read fetches a name store
// character, mode restart starts a new directory.
// Result queue: one result item per input item, in order, shown while empty
// is low and taken with pop.
// Throughput: one item per cycle in bursts while full is low. The back end
// stalls while it writes a decoded name into the store (one write port), at
// most once per 32-byte entry; the 16-deep command queue takes up the bursts.
// With empty queues an accepted item passes the command queue, then the read
// stage, and shows once it is written into the result queue.
// Reset clears position, pending sequence, end flag and both queues; the
// name store is not cleared. When pop stays low the result queue fills,
// then the command queue, then full rises.
// ----------------------------------------------------------------------------
module fat_directory_entry_parser import fdep_pkg::*; #(
  parameter int NAME_DEPTH = 256,
  parameter int CMD_DEPTH  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_entry_byte,
  input  logic [7:0]  in_read_index,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_event_res,
  output logic [7:0]  out_name_char,
  output logic        out_writable,
  output logic        out_hidden,
  output logic        out_directory,
  output logic [31:0] out_first_cluster,
  output logic [31:0] out_file_size
);

  logic accept;
  cmd_t fe_cmd, q_cmd;
  logic q_valid, q_pop;
  res_t res;

  assign accept = push && !full;

  fdep_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .mode       (in_mode),
    .entry_byte (in_entry_byte),
    .read_index (in_read_index),
    .cmd        (fe_cmd)
  );

  fdep_cmd_fifo #(.DEPTH(CMD_DEPTH)) u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (accept),
    .wr_data  (fe_cmd),
    .full     (full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_cmd)
  );

  fdep_back #(.NAME_DEPTH(NAME_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_pop   (q_pop),
    .res       (res),
    .res_empty (empty),
    .res_pop   (pop)
  );

  assign out_event_res     = res.ev;
  assign out_name_char     = res.name_char;
  assign out_writable      = res.writable;
  assign out_hidden        = res.hidden;
  assign out_directory     = res.directory;
  assign out_first_cluster = res.cluster;
  assign out_file_size     = res.size;

endmodule
